// ----- hw/rtl/round_robin_task_table_core_macros.svh -----
// Assertion macros shared by the round robin task table checker.
// Depends on signals named clk and rst in the scope where a macro is used.
`ifndef ROUND_ROBIN_TASK_TABLE_CORE_MACROS_SVH
`define ROUND_ROBIN_TASK_TABLE_CORE_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define RRT_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define RRT_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/rrt_pkg.sv -----
// Package for the round robin task table: field widths, command codes,
// sequencer states and the result record. No dependencies.
`timescale 1ns / 1ps

package rrt_pkg;

  localparam int MODE_W        = 3;
  localparam int ID_W          = 16;
  localparam int CTX_W         = 32;
  localparam int TASK_COUNT_W  = 9;
  localparam int MAX_TASKS_DEF = 256;

  localparam logic [MODE_W-1:0] MODE_ADD   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_TERM  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_YIELD = 3'd2;
  localparam logic [MODE_W-1:0] MODE_TICK  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_QUERY = 3'd4;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ADD,
    S_SEARCH,
    S_SHIFT,
    S_PLACE,
    S_TICK_SAVE,
    S_TICK_MOD,
    S_TICK_RD,
    S_TICK_DATA,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic             accepted;
    logic             present;
    logic [CTX_W-1:0] ctx;
    logic [ID_W-1:0]  id;
  } result_t;

endpackage

// ----- hw/rtl/rrt_if.sv -----
// Valid/ready channel interfaces for the task table: command words in,
// result words out. Depends on rrt_pkg for the field widths.
`timescale 1ns / 1ps

interface rrt_req_if import rrt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [ID_W-1:0]   task_id;
  logic [CTX_W-1:0]  context_req;

  modport source (output valid, mode, task_id, context_req, input ready);
  modport sink   (input valid, mode, task_id, context_req, output ready);
endinterface

interface rrt_rsp_if import rrt_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    accepted;
  logic                    present;
  logic [CTX_W-1:0]        next_context;
  logic [ID_W-1:0]         next_task_id;
  logic [TASK_COUNT_W-1:0] task_count;

  modport source (output valid, accepted, present, next_context, next_task_id,
                  task_count, input ready);
  modport sink   (input valid, accepted, present, next_context, next_task_id,
                  task_count, output ready);
endinterface

// ----- hw/rtl/round_robin_task_table_core.sv -----
// Round robin task table: an ordered list of task identifiers and saved
// context handles held in two RAMs and walked by one small sequencer.
// Depends on rrt_pkg, rrt_if and rrt_ram.
//
// Usage: command words arrive on req (mode, task_id, context_req) and every
// command gives exactly one result word on rsp. A command is taken only while
// the sequencer is idle; the next one can be accepted in the cycle after the
// result is registered. Steps per command:
//   add                      one write at the end of the table if there is room
//   query                    search, one RAM read per entry
//   terminate                search, then shift down
//   yield                    search, shift, then the final write
//   schedule tick            save the context, wrap the advanced pointer by
//                            repeated subtraction, then read the next entry
// Both RAMs share one read address: the search and the shift read one entry
// per cycle, and the tick reads a single entry. A finished result waits in
// the output register while the next command is accepted; if the receiver
// stalls, the sequencer holds the following result until the register
// frees up. Reset empties the table, clears the running pointer and needs no
// clearing pass: entries beyond the count are never read.
`timescale 1ns / 1ps

module round_robin_task_table_core import rrt_pkg::*; #(
  parameter int MAX_TASKS = MAX_TASKS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  rrt_req_if.sink    req,
  rrt_rsp_if.source  rsp
);

  localparam int IDX_W = $clog2(MAX_TASKS);
  localparam int CNT_W = $clog2(MAX_TASKS + 1);

  state_t state, state_next;

  logic [MODE_W-1:0] op_mode;
  logic [ID_W-1:0]   op_id;
  logic [CTX_W-1:0]  op_ctx;

  logic [CNT_W-1:0] count, count_next;
  logic [IDX_W-1:0] cur_idx, cur_idx_next;
  logic             cur_valid, cur_valid_next;
  logic [CNT_W-1:0] idx, idx_next;
  logic             rd_vld, rd_vld_next;
  logic [IDX_W-1:0] rd_slot, rd_slot_next;
  logic [ID_W-1:0]  hold_id, hold_id_next;
  logic [CTX_W-1:0] hold_ctx, hold_ctx_next;
  result_t          res, res_next;

  result_t                 out_res;
  logic [TASK_COUNT_W-1:0] out_count;
  logic                    out_valid;

  logic             id_we, ctx_we;
  logic [IDX_W-1:0] waddr, raddr;
  logic [ID_W-1:0]  id_wdata, id_rdata;
  logic [CTX_W-1:0] ctx_wdata, ctx_rdata;

  logic             hit, scan_end, out_free, room;
  logic [CNT_W-1:0] last_slot;

  assign hit       = rd_vld && (id_rdata == op_id);
  assign scan_end  = !rd_vld && (idx >= count);
  assign out_free  = !out_valid || rsp.ready;
  assign room      = count < CNT_W'(MAX_TASKS);
  assign last_slot = count - CNT_W'(1);

  rrt_ram #(.WIDTH(ID_W), .DEPTH(MAX_TASKS)) u_id_ram (
    .clk   (clk),
    .we    (id_we),
    .waddr (waddr),
    .wdata (id_wdata),
    .raddr (raddr),
    .rdata (id_rdata)
  );

  rrt_ram #(.WIDTH(CTX_W), .DEPTH(MAX_TASKS)) u_ctx_ram (
    .clk   (clk),
    .we    (ctx_we),
    .waddr (waddr),
    .wdata (ctx_wdata),
    .raddr (raddr),
    .rdata (ctx_rdata)
  );

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req.valid) begin
          case (req.mode)
            MODE_ADD:   state_next = S_ADD;
            MODE_TERM:  state_next = S_SEARCH;
            MODE_YIELD: state_next = S_SEARCH;
            MODE_QUERY: state_next = S_SEARCH;
            MODE_TICK:  state_next = S_TICK_SAVE;
            default:    state_next = S_EMIT;
          endcase
        end
      end
      S_ADD: state_next = S_EMIT;
      S_SEARCH: begin
        if (hit) begin
          state_next = (op_mode == MODE_QUERY) ? S_EMIT : S_SHIFT;
        end else if (scan_end) begin
          state_next = S_EMIT;
        end
      end
      S_SHIFT: begin
        if (scan_end) begin
          state_next = (op_mode == MODE_YIELD) ? S_PLACE : S_EMIT;
        end
      end
      S_PLACE: state_next = S_EMIT;
      S_TICK_SAVE: state_next = (count == '0) ? S_EMIT : S_TICK_MOD;
      S_TICK_MOD: begin
        if (idx < count) begin
          state_next = S_TICK_RD;
        end
      end
      S_TICK_RD:   state_next = S_TICK_DATA;
      S_TICK_DATA: state_next = S_EMIT;
      S_EMIT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Datapath and RAM control. The search and the shift keep one read in
  // flight: the entry is looked at in the cycle after its address goes out.
  always_comb begin
    count_next     = count;
    cur_idx_next   = cur_idx;
    cur_valid_next = cur_valid;
    idx_next       = idx;
    rd_vld_next    = rd_vld;
    rd_slot_next   = rd_slot;
    hold_id_next   = hold_id;
    hold_ctx_next  = hold_ctx;
    res_next       = res;
    id_we          = 1'b0;
    ctx_we         = 1'b0;
    waddr          = '0;
    raddr          = '0;
    id_wdata       = op_id;
    ctx_wdata      = op_ctx;
    case (state)
      S_IDLE: begin
        if (req.valid) begin
          res_next    = '0;
          idx_next    = '0;
          rd_vld_next = 1'b0;
        end
      end
      S_ADD: begin
        if (room) begin
          id_we             = 1'b1;
          ctx_we            = 1'b1;
          waddr             = count[IDX_W-1:0];
          count_next        = count + CNT_W'(1);
          res_next.accepted = 1'b1;
        end
      end
      S_SEARCH: begin
        if (hit) begin
          hold_id_next  = id_rdata;
          hold_ctx_next = ctx_rdata;
          idx_next      = CNT_W'(rd_slot) + CNT_W'(1);
          rd_vld_next   = 1'b0;
          if (op_mode == MODE_QUERY) begin
            res_next.accepted = 1'b1;
            res_next.present  = 1'b1;
          end
        end else if (idx < count) begin
          raddr        = idx[IDX_W-1:0];
          idx_next     = idx + CNT_W'(1);
          rd_vld_next  = 1'b1;
          rd_slot_next = idx[IDX_W-1:0];
        end else begin
          rd_vld_next = 1'b0;
        end
      end
      S_SHIFT: begin
        // Each entry read at slot k+1 is written back one slot lower.
        if (rd_vld) begin
          id_we     = 1'b1;
          ctx_we    = 1'b1;
          waddr     = rd_slot - IDX_W'(1);
          id_wdata  = id_rdata;
          ctx_wdata = ctx_rdata;
        end
        if (scan_end) begin
          if (op_mode == MODE_TERM) begin
            count_next        = last_slot;
            res_next.accepted = 1'b1;
          end
        end else if (idx < count) begin
          raddr        = idx[IDX_W-1:0];
          idx_next     = idx + CNT_W'(1);
          rd_vld_next  = 1'b1;
          rd_slot_next = idx[IDX_W-1:0];
        end else begin
          rd_vld_next = 1'b0;
        end
      end
      S_PLACE: begin
        id_we             = 1'b1;
        ctx_we            = 1'b1;
        waddr             = last_slot[IDX_W-1:0];
        id_wdata          = hold_id;
        ctx_wdata         = hold_ctx;
        res_next.accepted = 1'b1;
      end
      S_TICK_SAVE: begin
        if (count == '0) begin
          res_next.ctx = op_ctx;
        end else begin
          if (cur_valid && (CNT_W'(cur_idx) < count)) begin
            ctx_we = 1'b1;
            waddr  = cur_idx;
          end
          idx_next = cur_valid ? CNT_W'(cur_idx) + CNT_W'(1) : '0;
        end
      end
      S_TICK_MOD: begin
        // Repeated subtraction wraps the advanced pointer into the table.
        if (idx >= count) begin
          idx_next = idx - count;
        end else begin
          cur_idx_next   = idx[IDX_W-1:0];
          cur_valid_next = 1'b1;
        end
      end
      S_TICK_RD: begin
        raddr = cur_idx;
      end
      S_TICK_DATA: begin
        res_next.ctx = ctx_rdata;
        res_next.id  = id_rdata;
      end
      S_EMIT: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      cur_idx   <= '0;
      cur_valid <= 1'b0;
      rd_vld    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      cur_idx   <= cur_idx_next;
      cur_valid <= cur_valid_next;
      rd_vld    <= rd_vld_next;
      if ((state == S_EMIT) && out_free) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx      <= idx_next;
    rd_slot  <= rd_slot_next;
    hold_id  <= hold_id_next;
    hold_ctx <= hold_ctx_next;
    res      <= res_next;
    if ((state == S_IDLE) && req.valid) begin
      op_mode <= req.mode;
      op_id   <= req.task_id;
      op_ctx  <= req.context_req;
    end
    if ((state == S_EMIT) && out_free) begin
      out_res   <= res;
      out_count <= TASK_COUNT_W'(count);
    end
  end

  assign req.ready        = (state == S_IDLE);
  assign rsp.valid        = out_valid;
  assign rsp.accepted     = out_res.accepted;
  assign rsp.present      = out_res.present;
  assign rsp.next_context = out_res.ctx;
  assign rsp.next_task_id = out_res.id;
  assign rsp.task_count   = out_count;

endmodule

// ----- hw/rtl/rrt_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; contents are undefined until written.
`timescale 1ns / 1ps

module rrt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/rrt_checker.sv -----
// Port-level checks for the round robin task table, bound to the core module.
// Depends on rrt_pkg and the assertion macros header.
`timescale 1ns / 1ps
`include "round_robin_task_table_core_macros.svh"

module rrt_checker import rrt_pkg::*; (
  input logic                    clk,
  input logic                    rst,
  input logic                    req_valid,
  input logic                    req_ready,
  input logic                    rsp_valid,
  input logic                    rsp_ready,
  input logic                    rsp_accepted,
  input logic                    rsp_present,
  input logic [TASK_COUNT_W-1:0] task_count
);

  // The sequencer is busy in the cycle after it accepts a command.
  `RRT_ASSERT_NXT(a_busy_after_accept, req_valid && req_ready, !req_ready,
    "command accepted while the sequencer should be busy")

  // A new result only appears when the sequencer was busy just before it, with commands blocked.
  `RRT_ASSERT_IMP(a_result_from_busy, $rose(rsp_valid), $past(!req_ready),
    "result word appeared while the block was idle")

  // A task that is reported present is also flagged as accepted.
  `RRT_ASSERT_IMP(a_present_found, rsp_valid && rsp_present, rsp_accepted,
    "present flag set without accepted flag")

  `RRT_ASSERT_NXT(a_stall_holds, rsp_valid && !rsp_ready,
    rsp_valid && $stable(task_count),
    "stalled result word changed or dropped")

endmodule

bind round_robin_task_table_core rrt_checker u_rrt_checker (
  .clk          (clk),
  .rst          (rst),
  .req_valid    (req.valid),
  .req_ready    (req.ready),
  .rsp_valid    (rsp.valid),
  .rsp_ready    (rsp.ready),
  .rsp_accepted (rsp.accepted),
  .rsp_present  (rsp.present),
  .task_count   (rsp.task_count)
);
